FILE: design/ffsa_pkg.sv
package ffsa_pkg;

   localparam int HEAP_WORDS_DEF   = 1024;
   localparam int MAX_SEGMENTS_DEF = 16;
   localparam int MAX_BLOCKS_DEF   = 16;
   localparam int ID_W             = 8;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_OK       = 3'd0;
   localparam status_type STATUS_NOFIT    = 3'd1;
   localparam status_type STATUS_NOTFOUND = 3'd2;
   localparam status_type STATUS_FULL     = 3'd3;
   localparam status_type STATUS_ZERO     = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_BS_RD,
      S_BS_CHK,
      S_REL_RD,
      S_REL_CHK,
      S_REL_DEC,
      S_SH_RD,
      S_SH_WR,
      S_REL_OK,
      S_FIT_RD,
      S_FIT_CHK,
      S_ALLOC_OK
   } state_type;

   typedef enum logic [1:0] {
      PH_FREE,
      PH_REPL,
      PH_FIT
   } phase_type;

endpackage

FILE: design/first_fit_segment_allocator.sv
// Channel   | Ports                                                  | Handshake
// ----------+--------------------------------------------------------+----------------------
// request   | req_operation, req_block_id, req_request_size          | start high, busy low
// response  | rsp_status, rsp_start_addr, rsp_block_size, rsp_replaced | rsp_valid, one cycle
//
// Busy stays high while the block table is scanned: each live slot up to the match is read and
// then checked, empty slots are skipped, and the scan is closed when no id matches. Each ordered
// free-table search reads and then checks one entry at a time. A segment is placed in a single
// step. A shift reads and writes each entry moved, then finishes. The request is then retired.
// Zero-size allocates answer next cycle, not busy.
// After reset the free table is seeded in S_INIT; busy is high meanwhile.
// Results cannot be stalled: each one is shown for one cycle with rsp_valid.
module first_fit_segment_allocator #(
   parameter int HEAP_WORDS   = ffsa_pkg::HEAP_WORDS_DEF,
   parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
   parameter int MAX_BLOCKS   = ffsa_pkg::MAX_BLOCKS_DEF,
   localparam int AW = $clog2(HEAP_WORDS),
   localparam int LW = $clog2(HEAP_WORDS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic [ffsa_pkg::ID_W-1:0] req_block_id,
   input  logic [LW-1:0]             req_request_size,
   output logic                      rsp_valid,
   output ffsa_pkg::status_type      rsp_status,
   output logic [AW-1:0]             rsp_start_addr,
   output logic [LW-1:0]             rsp_block_size,
   output logic                      rsp_replaced
);

   localparam int SW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int BW = $clog2(MAX_BLOCKS);
   localparam int JW = $clog2(MAX_BLOCKS + 1);
   localparam int EW = LW + 1;

   ffsa_pkg::state_type state_ff, state_in;
   ffsa_pkg::phase_type phase_ff, phase_in;

   logic                      op_ff, op_in;
   logic [ffsa_pkg::ID_W-1:0] id_ff, id_in;
   logic [LW-1:0]             n_ff, n_in;
   logic [AW-1:0]             s_ff, s_in;
   logic [LW-1:0]             l_ff, l_in;
   logic [BW-1:0]             k_ff, k_in;
   logic [BW-1:0]             fs_ff, fs_in;
   logic                      fsok_ff, fsok_in;
   logic [JW-1:0]             j_ff, j_in;
   logic [CW-1:0]             p_ff, p_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             sh_ff, sh_in;
   logic                      ins_ff, ins_in;
   logic                      repl_ff, repl_in;
   logic [AW-1:0]             prev_s_ff, prev_s_in;
   logic [LW-1:0]             prev_l_ff, prev_l_in;
   logic [MAX_BLOCKS-1:0]     valid_ff, valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [AW-1:0]             rsp_addr_ff, rsp_addr_in;
   logic [LW-1:0]             rsp_size_ff, rsp_size_in;
   logic                      rsp_repl_ff, rsp_repl_in;

   // free-segment table
   logic [AW-1:0] fs_mem [MAX_SEGMENTS];
   logic [LW-1:0] fl_mem [MAX_SEGMENTS];
   logic [AW-1:0] frd_s_ff;
   logic [LW-1:0] frd_l_ff;
   logic          f_re, f_we;
   logic [SW-1:0] f_raddr, f_waddr;
   logic [AW-1:0] f_wd_s;
   logic [LW-1:0] f_wd_l;

   // used-block table
   logic [ffsa_pkg::ID_W-1:0] bid_mem [MAX_BLOCKS];
   logic [AW-1:0]             bs_mem  [MAX_BLOCKS];
   logic [LW-1:0]             bl_mem  [MAX_BLOCKS];
   logic [ffsa_pkg::ID_W-1:0] brd_id_ff;
   logic [AW-1:0]             brd_s_ff;
   logic [LW-1:0]             brd_l_ff;
   logic                      b_re, b_we;
   logic [BW-1:0]             b_raddr;

   logic          j_end, p_end, cur_ok, left_hit, right_hit, cnt_full, sh_more;
   logic [BW-1:0] jidx;
   logic [CW-1:0] pm1;

   assign jidx     = j_ff[BW-1:0];
   assign j_end    = (j_ff == JW'(MAX_BLOCKS));
   assign p_end    = (p_ff == cnt_ff);
   assign cur_ok   = !p_end;
   assign pm1      = CW'(p_ff - 1'b1);
   assign cnt_full = (cnt_ff == CW'(MAX_SEGMENTS));
   assign left_hit = (p_ff != '0) &&
                     ((EW'(prev_s_ff) + EW'(prev_l_ff)) == EW'(s_ff));
   assign right_hit = cur_ok && ((EW'(s_ff) + EW'(l_ff)) == EW'(frd_s_ff));
   assign sh_more  = ins_ff ? (sh_ff > p_ff) : (CW'(sh_ff + 1'b1) < cnt_ff);

   assign busy           = (state_ff != ffsa_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_addr = rsp_addr_ff;
   assign rsp_block_size = rsp_size_ff;
   assign rsp_replaced   = rsp_repl_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffsa_pkg::S_INIT: state_in = ffsa_pkg::S_IDLE;
         ffsa_pkg::S_IDLE: begin
            if (start && !(req_operation == ffsa_pkg::OP_ALLOC && req_request_size == '0))
               state_in = ffsa_pkg::S_BS_RD;
         end
         ffsa_pkg::S_BS_RD: begin
            if (j_end) begin
               if (op_ff == ffsa_pkg::OP_ALLOC && fsok_ff) state_in = ffsa_pkg::S_FIT_RD;
               else state_in = ffsa_pkg::S_IDLE;
            end else if (valid_ff[jidx]) begin
               state_in = ffsa_pkg::S_BS_CHK;
            end
         end
         ffsa_pkg::S_BS_CHK: begin
            if (brd_id_ff == id_ff) state_in = ffsa_pkg::S_REL_RD;
            else state_in = ffsa_pkg::S_BS_RD;
         end
         ffsa_pkg::S_REL_RD: state_in = p_end ? ffsa_pkg::S_REL_DEC : ffsa_pkg::S_REL_CHK;
         ffsa_pkg::S_REL_CHK: begin
            if (frd_s_ff < s_ff) state_in = ffsa_pkg::S_REL_RD;
            else state_in = ffsa_pkg::S_REL_DEC;
         end
         ffsa_pkg::S_REL_DEC: begin
            if (left_hit && right_hit) state_in = ffsa_pkg::S_SH_RD;
            else if (left_hit || right_hit) state_in = ffsa_pkg::S_REL_OK;
            else if (cnt_full) state_in = ffsa_pkg::S_IDLE;
            else state_in = ffsa_pkg::S_SH_RD;
         end
         ffsa_pkg::S_SH_RD: begin
            if (sh_more) state_in = ffsa_pkg::S_SH_WR;
            else if (!ins_ff && phase_ff == ffsa_pkg::PH_FIT) state_in = ffsa_pkg::S_ALLOC_OK;
            else state_in = ffsa_pkg::S_REL_OK;
         end
         ffsa_pkg::S_SH_WR: state_in = ffsa_pkg::S_SH_RD;
         ffsa_pkg::S_REL_OK: begin
            if (phase_ff == ffsa_pkg::PH_FREE) state_in = ffsa_pkg::S_IDLE;
            else state_in = ffsa_pkg::S_FIT_RD;
         end
         ffsa_pkg::S_FIT_RD: state_in = p_end ? ffsa_pkg::S_IDLE : ffsa_pkg::S_FIT_CHK;
         ffsa_pkg::S_FIT_CHK: begin
            if (frd_l_ff < n_ff) state_in = ffsa_pkg::S_FIT_RD;
            else if (frd_l_ff > n_ff) state_in = ffsa_pkg::S_ALLOC_OK;
            else state_in = ffsa_pkg::S_SH_RD;
         end
         ffsa_pkg::S_ALLOC_OK: state_in = ffsa_pkg::S_IDLE;
         default: state_in = ffsa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      l_in          = l_ff;
      k_in          = k_ff;
      fs_in         = fs_ff;
      fsok_in       = fsok_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      cnt_in        = cnt_ff;
      sh_in         = sh_ff;
      ins_in        = ins_ff;
      repl_in       = repl_ff;
      prev_s_in     = prev_s_ff;
      prev_l_in     = prev_l_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_repl_in   = rsp_repl_ff;
      f_re          = 1'b0;
      f_raddr       = '0;
      f_we          = 1'b0;
      f_waddr       = '0;
      f_wd_s        = '0;
      f_wd_l        = '0;
      b_re          = 1'b0;
      b_raddr       = '0;
      b_we          = 1'b0;

      unique case (state_ff)
         ffsa_pkg::S_INIT: begin
            // seed the whole heap as one free segment
            f_we   = 1'b1;
            f_wd_l = LW'(HEAP_WORDS);
         end
         ffsa_pkg::S_IDLE: begin
            if (start) begin
               op_in   = req_operation;
               id_in   = req_block_id;
               n_in    = req_request_size;
               j_in    = '0;
               fsok_in = 1'b0;
               repl_in = 1'b0;
               if (req_operation == ffsa_pkg::OP_ALLOC && req_request_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffsa_pkg::STATUS_ZERO;
                  rsp_addr_in   = '0;
                  rsp_size_in   = '0;
                  rsp_repl_in   = 1'b0;
               end
            end
         end
         ffsa_pkg::S_BS_RD: begin
            if (j_end) begin
               if (op_ff == ffsa_pkg::OP_ALLOC && fsok_ff) begin
                  p_in     = '0;
                  phase_in = ffsa_pkg::PH_FIT;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (op_ff == ffsa_pkg::OP_FREE) ? ffsa_pkg::STATUS_NOTFOUND
                                                                : ffsa_pkg::STATUS_FULL;
                  rsp_addr_in   = '0;
                  rsp_size_in   = '0;
                  rsp_repl_in   = 1'b0;
               end
            end else if (!valid_ff[jidx]) begin
               // note the lowest empty slot on the way
               if (!fsok_ff) begin
                  fs_in   = jidx;
                  fsok_in = 1'b1;
               end
               j_in = JW'(j_ff + 1'b1);
            end else begin
               b_re    = 1'b1;
               b_raddr = jidx;
            end
         end
         ffsa_pkg::S_BS_CHK: begin
            if (brd_id_ff == id_ff) begin
               s_in     = brd_s_ff;
               l_in     = brd_l_ff;
               k_in     = jidx;
               p_in     = '0;
               phase_in = (op_ff == ffsa_pkg::OP_FREE) ? ffsa_pkg::PH_FREE
                                                       : ffsa_pkg::PH_REPL;
            end else begin
               j_in = JW'(j_ff + 1'b1);
            end
         end
         ffsa_pkg::S_REL_RD: begin
            if (!p_end) begin
               f_re    = 1'b1;
               f_raddr = p_ff[SW-1:0];
            end
         end
         ffsa_pkg::S_REL_CHK: begin
            if (frd_s_ff < s_ff) begin
               prev_s_in = frd_s_ff;
               prev_l_in = frd_l_ff;
               p_in      = CW'(p_ff + 1'b1);
            end
         end
         ffsa_pkg::S_REL_DEC: begin
            if (left_hit && right_hit) begin
               f_we    = 1'b1;
               f_waddr = pm1[SW-1:0];
               f_wd_s  = prev_s_ff;
               f_wd_l  = LW'(prev_l_ff + l_ff + frd_l_ff);
               sh_in   = p_ff;
               ins_in  = 1'b0;
            end else if (left_hit) begin
               f_we    = 1'b1;
               f_waddr = pm1[SW-1:0];
               f_wd_s  = prev_s_ff;
               f_wd_l  = LW'(prev_l_ff + l_ff);
            end else if (right_hit) begin
               f_we    = 1'b1;
               f_waddr = p_ff[SW-1:0];
               f_wd_s  = s_ff;
               f_wd_l  = LW'(frd_l_ff + l_ff);
            end else if (cnt_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffsa_pkg::STATUS_FULL;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               rsp_repl_in   = 1'b0;
            end else begin
               sh_in  = cnt_ff;
               ins_in = 1'b1;
            end
         end
         ffsa_pkg::S_SH_RD: begin
            if (sh_more) begin
               f_re    = 1'b1;
               f_raddr = ins_ff ? SW'(sh_ff - 1'b1) : SW'(sh_ff + 1'b1);
            end else if (ins_ff) begin
               // open gap reached: drop the segment in
               f_we    = 1'b1;
               f_waddr = p_ff[SW-1:0];
               f_wd_s  = s_ff;
               f_wd_l  = l_ff;
               cnt_in  = CW'(cnt_ff + 1'b1);
            end else begin
               cnt_in = CW'(cnt_ff - 1'b1);
            end
         end
         ffsa_pkg::S_SH_WR: begin
            f_we    = 1'b1;
            f_waddr = sh_ff[SW-1:0];
            f_wd_s  = frd_s_ff;
            f_wd_l  = frd_l_ff;
            sh_in   = ins_ff ? CW'(sh_ff - 1'b1) : CW'(sh_ff + 1'b1);
         end
         ffsa_pkg::S_REL_OK: begin
            valid_in[k_ff] = 1'b0;
            if (phase_ff == ffsa_pkg::PH_FREE) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffsa_pkg::STATUS_OK;
               rsp_addr_in   = s_ff;
               rsp_size_in   = l_ff;
               rsp_repl_in   = 1'b0;
            end else begin
               repl_in  = 1'b1;
               p_in     = '0;
               phase_in = ffsa_pkg::PH_FIT;
               if (!fsok_ff) begin
                  fs_in   = k_ff;
                  fsok_in = 1'b1;
               end
            end
         end
         ffsa_pkg::S_FIT_RD: begin
            if (p_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffsa_pkg::STATUS_NOFIT;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               rsp_repl_in   = repl_ff;
            end else begin
               f_re    = 1'b1;
               f_raddr = p_ff[SW-1:0];
            end
         end
         ffsa_pkg::S_FIT_CHK: begin
            if (frd_l_ff < n_ff) begin
               p_in = CW'(p_ff + 1'b1);
            end else begin
               s_in = frd_s_ff;
               if (frd_l_ff > n_ff) begin
                  // carve from the low end, keep the rest
                  f_we    = 1'b1;
                  f_waddr = p_ff[SW-1:0];
                  f_wd_s  = AW'(frd_s_ff + n_ff[AW-1:0]);
                  f_wd_l  = LW'(frd_l_ff - n_ff);
               end else begin
                  sh_in  = p_ff;
                  ins_in = 1'b0;
               end
            end
         end
         ffsa_pkg::S_ALLOC_OK: begin
            b_we            = 1'b1;
            valid_in[fs_ff] = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = ffsa_pkg::STATUS_OK;
            rsp_addr_in     = s_ff;
            rsp_size_in     = n_ff;
            rsp_repl_in     = repl_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::S_INIT;
         phase_ff     <= ffsa_pkg::PH_FREE;
         cnt_ff       <= CW'(1);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      n_ff          <= n_in;
      s_ff          <= s_in;
      l_ff          <= l_in;
      k_ff          <= k_in;
      fs_ff         <= fs_in;
      fsok_ff       <= fsok_in;
      j_ff          <= j_in;
      p_ff          <= p_in;
      sh_ff         <= sh_in;
      ins_ff        <= ins_in;
      repl_ff       <= repl_in;
      prev_s_ff     <= prev_s_in;
      prev_l_ff     <= prev_l_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_repl_ff   <= rsp_repl_in;
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fs_mem[f_waddr] <= f_wd_s;
         fl_mem[f_waddr] <= f_wd_l;
      end
      if (f_re) begin
         frd_s_ff <= fs_mem[f_raddr];
         frd_l_ff <= fl_mem[f_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bid_mem[fs_ff] <= id_ff;
         bs_mem[fs_ff]  <= s_ff;
         bl_mem[fs_ff]  <= n_ff;
      end
      if (b_re) begin
         brd_id_ff <= bid_mem[b_raddr];
         brd_s_ff  <= bs_mem[b_raddr];
         brd_l_ff  <= bl_mem[b_raddr];
      end
   end

endmodule

FILE: design/ffsa_checker.sv
module ffsa_checker #(
   parameter int HEAP_WORDS = ffsa_pkg::HEAP_WORDS_DEF,
   localparam int AW = $clog2(HEAP_WORDS),
   localparam int LW = $clog2(HEAP_WORDS + 1)
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 req_operation,
   input logic                 rsp_valid,
   input ffsa_pkg::status_type rsp_status,
   input logic [AW-1:0]        rsp_start_addr,
   input logic [LW-1:0]        rsp_block_size,
   input logic                 rsp_replaced
);

   // an accepted word either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_fail_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffsa_pkg::STATUS_OK) |->
         (rsp_start_addr == '0 && rsp_block_size == '0))
      else $error("failed request reports a segment");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ffsa_pkg::STATUS_OK) |-> (rsp_block_size != '0))
      else $error("successful request reports an empty block");

   a_free_no_repl: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == ffsa_pkg::OP_FREE) |=>
         (!rsp_valid || !rsp_replaced))
      else $error("free request flagged a replacement");

endmodule

bind first_fit_segment_allocator ffsa_checker #(.HEAP_WORDS(HEAP_WORDS)) u_ffsa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_start_addr (rsp_start_addr),
   .rsp_block_size (rsp_block_size),
   .rsp_replaced   (rsp_replaced)
);
